// ===== rtl/vmiad_pkg.sv =====
// ----------------------------------------------------------------------------
// vmiad_pkg
// Shared types and constants for the instruction argument decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package vmiad_pkg;

    localparam int NUM_ARGS      = 3;
    localparam int REG_COUNT_DEF = 16;
    localparam int WIN_BYTES     = 12;
    localparam int WIN_W         = WIN_BYTES * 8;

    localparam logic [3:0] OFFSET_FIRST = 4'd2;
    localparam logic [3:0] OFFSET_LAST  = 4'd14;

    localparam logic [1:0] TYPE_NONE = 2'd0;
    localparam logic [1:0] TYPE_REG  = 2'd1;
    localparam logic [1:0] TYPE_DIR  = 2'd2;
    localparam logic [1:0] TYPE_IND  = 2'd3;

    localparam logic [2:0] DSIZE_SHORT = 3'd2;
    localparam logic [2:0] DSIZE_WORD  = 3'd4;

    typedef struct packed {
        logic [7:0]              code;
        logic [1:0]              cnt;
        logic [2:0]              dsize;
        logic [3*NUM_ARGS-1:0]   masks;
        logic [WIN_W-1:0]        win;
        logic [3:0]              off;
        logic                    ok;
        logic [2*NUM_ARGS-1:0]   types;
        logic [32*NUM_ARGS-1:0]  vals;
    } pipe_t;

endpackage

`default_nettype wire

// ===== rtl/vmiad_cell.sv =====
// ----------------------------------------------------------------------------
// vmiad_cell
// One decode cell: decodes the leading argument, consumes its bytes and
// hands the rest of the beat to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module vmiad_cell #(
    parameter int REG_COUNT = vmiad_pkg::REG_COUNT_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  vmiad_pkg::pipe_t     in_data,
    output logic                 out_valid,
    output vmiad_pkg::pipe_t     out_data
);

    localparam logic [7:0] RegMax = 8'(REG_COUNT);

    logic              valid_reg;
    vmiad_pkg::pipe_t  data_reg;
    vmiad_pkg::pipe_t  data_next;

    logic        en;
    logic [1:0]  t;
    logic [2:0]  mask;
    logic [7:0]  b0, b1, b2, b3;
    logic [31:0] v_short;
    logic [31:0] v_word;
    logic [31:0] v;
    logic [2:0]  adv;
    logic        good;

    always_comb
    begin
        en      = in_data.cnt != 2'd0;
        t       = en ? in_data.code[7:6] : vmiad_pkg::TYPE_NONE;
        mask    = in_data.masks[3*vmiad_pkg::NUM_ARGS-1 -: 3];
        b0      = in_data.win[vmiad_pkg::WIN_W-1  -: 8];
        b1      = in_data.win[vmiad_pkg::WIN_W-9  -: 8];
        b2      = in_data.win[vmiad_pkg::WIN_W-17 -: 8];
        b3      = in_data.win[vmiad_pkg::WIN_W-25 -: 8];
        v_short = {{16{b0[7]}}, b0, b1};
        v_word  = {b0, b1, b2, b3};
        v       = 32'd0;
        adv     = 3'd0;
        good    = 1'b1;
        case (t)
            vmiad_pkg::TYPE_REG:
            begin
                v    = {24'd0, b0};
                adv  = 3'd1;
                good = mask[0] && (b0 != 8'd0) && (b0 <= RegMax);
            end
            vmiad_pkg::TYPE_DIR:
            begin
                good = mask[1];
                if (in_data.dsize == vmiad_pkg::DSIZE_WORD)
                begin
                    v   = v_word;
                    adv = 3'd4;
                end
                else
                begin
                    v   = v_short;
                    adv = (in_data.dsize == vmiad_pkg::DSIZE_SHORT) ? 3'd2 : 3'd4;
                end
            end
            vmiad_pkg::TYPE_IND:
            begin
                v    = v_short;
                adv  = 3'd2;
                good = mask[2];
            end
            default:
            begin
                good = !en;
            end
        endcase

        data_next       = in_data;
        data_next.code  = {in_data.code[5:0], 2'b00};
        data_next.cnt   = en ? in_data.cnt - 2'd1 : 2'd0;
        data_next.masks = {in_data.masks[3*vmiad_pkg::NUM_ARGS-4:0], 3'b000};
        data_next.off   = in_data.off + {1'b0, adv};
        data_next.ok    = in_data.ok && good;
        data_next.types = {in_data.types[2*vmiad_pkg::NUM_ARGS-3:0], t};
        data_next.vals  = {in_data.vals[32*vmiad_pkg::NUM_ARGS-33:0], v};
        case (adv)
            3'd1:    data_next.win = in_data.win << 8;
            3'd2:    data_next.win = in_data.win << 16;
            3'd4:    data_next.win = in_data.win << 32;
            default: data_next.win = in_data.win;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ===== rtl/vm_instruction_argument_decoder_core.sv =====
// ----------------------------------------------------------------------------
// vm_instruction_argument_decoder_core
// Argument decoder: a row of three cells, one argument per cell.
// ----------------------------------------------------------------------------
// The start beat passes through the three cell registers to the done strobe.
// Throughput: one instruction per cycle; busy is always low.
// Each cell decodes one argument and forwards the beat to its neighbor.
// Reset clears the cell valid bits; no result is in flight after reset.
// The receiver cannot stall; each result is shown for one cycle.
`default_nettype none

module vm_instruction_argument_decoder_core #(
    parameter int REG_COUNT = vmiad_pkg::REG_COUNT_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [7:0]         argcode,
    input  wire logic [1:0]         arg_count,
    input  wire logic [2:0]         direct_size,
    input  wire logic [2:0]         allowed_first,
    input  wire logic [2:0]         allowed_second,
    input  wire logic [2:0]         allowed_third,
    input  wire logic [63:0]        bytes_lo,
    input  wire logic [31:0]        bytes_hi,
    output logic                    done,
    output logic [1:0]              type_first,
    output logic [1:0]              type_second,
    output logic [1:0]              type_third,
    output logic signed [31:0]      value_first,
    output logic signed [31:0]      value_second,
    output logic signed [31:0]      value_third,
    output logic                    args_valid,
    output logic [3:0]              instr_length
);

    logic             stg_valid [vmiad_pkg::NUM_ARGS+1];
    vmiad_pkg::pipe_t stg_data  [vmiad_pkg::NUM_ARGS+1];
    vmiad_pkg::pipe_t last;

    assign busy = 1'b0;

    always_comb
    begin
        stg_valid[0]       = start;
        stg_data[0].code   = argcode;
        stg_data[0].cnt    = arg_count;
        stg_data[0].dsize  = direct_size;
        stg_data[0].masks  = {allowed_first, allowed_second, allowed_third};
        stg_data[0].win    = {bytes_lo, bytes_hi};
        stg_data[0].off    = vmiad_pkg::OFFSET_FIRST;
        stg_data[0].ok     = 1'b1;
        stg_data[0].types  = '0;
        stg_data[0].vals   = '0;
    end

    for (genvar i = 0; i < vmiad_pkg::NUM_ARGS; i++)
    begin : g_cell
        vmiad_cell #(
            .REG_COUNT (REG_COUNT)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stg_valid[i]),
            .in_data   (stg_data[i]),
            .out_valid (stg_valid[i+1]),
            .out_data  (stg_data[i+1])
        );
    end

    assign last         = stg_data[vmiad_pkg::NUM_ARGS];
    assign done         = stg_valid[vmiad_pkg::NUM_ARGS];
    assign type_first   = last.types[5:4];
    assign type_second  = last.types[3:2];
    assign type_third   = last.types[1:0];
    assign value_first  = last.vals[95:64];
    assign value_second = last.vals[63:32];
    assign value_third  = last.vals[31:0];
    assign args_valid   = last.ok;
    assign instr_length = last.off;

`ifndef SYNTHESIS
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");
    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (instr_length >= vmiad_pkg::OFFSET_FIRST)
              && (instr_length <= vmiad_pkg::OFFSET_LAST))
        else $error("instruction length out of range");
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (type_first == vmiad_pkg::TYPE_NONE) |-> value_first == 32'sd0)
        else $error("empty argument with value");
    a_reg_byte: assert property (@(posedge clk) disable iff (!rst_n)
        done && (type_second == vmiad_pkg::TYPE_REG) |-> value_second[31:8] == 24'd0)
        else $error("register value wider than a byte");
    a_none_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        done && (type_first == vmiad_pkg::TYPE_NONE) && (instr_length != 4'd2)
        |-> !args_valid)
        else $error("empty argument flagged valid");
`endif

endmodule

`default_nettype wire
